[src/sbdf_pkg.sv]
// shared types, widths and register codes for the single-bin dft sub-vector folder
package sbdf_pkg;

	localparam int SBDF_MAX_POINTS = 65536;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 32;
	localparam int GAIN_W     = 32;
	localparam int PPV_W      = 17;
	localparam int ACC_W      = 64;
	localparam int VEC_W      = 48;
	localparam int SUM_W      = 56;
	localparam int VIDX_W     = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int INQ_DEPTH  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_A    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_GAIN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PPV       = 4'd3;

	localparam logic signed [COEF_W-1:0] COEF_A_RST    = 32'sd0;
	localparam logic signed [COEF_W-1:0] COEF_B_RST    = 32'sd0;
	localparam logic [GAIN_W-1:0]        NORM_GAIN_RST = 32'd65536;
	localparam logic [PPV_W-1:0]         PPV_RST       = 17'd1024;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       start_req;
	} in_item_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] vec_real;
		logic signed [VEC_W-1:0] vec_imag;
		logic signed [SUM_W-1:0] total_real;
		logic signed [SUM_W-1:0] total_imag;
		logic [VIDX_W-1:0]       vector_index;
	} result_t;

	typedef struct packed {
		logic load;
		logic mag;
		logic mul;
		logic comb;
		logic fin;
	} scale_ctl_t;

endpackage

[src/sbdf_inq.sv]
// front request queue: accepts samples and hands them to the core in order
module sbdf_inq import sbdf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t wr_item,
	output logic     full,
	input  logic     rd,
	output logic     rd_valid,
	output in_item_t rd_item
);

	localparam int PTR_W = (INQ_DEPTH > 1) ? $clog2(INQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(INQ_DEPTH + 1);

	in_item_t         mem_q [INQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_en;
	logic             rd_en;

	assign full     = (count_q == CNT_W'(INQ_DEPTH));
	assign rd_valid = (count_q != '0);
	assign wr_en    = push && !full;
	assign rd_en    = rd && rd_valid;
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(INQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(INQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/sbdf_scale.sv]
// one lane of the output scaler: floor(acc * gain / 2^16) saturated to 48 bits
module sbdf_scale import sbdf_pkg::*; (
	input  logic                    clk,
	input  scale_ctl_t              ctl,
	input  logic signed [ACC_W-1:0] acc,
	input  logic [GAIN_W-1:0]       gain,
	output logic signed [VEC_W-1:0] vec
);

	localparam logic [ACC_W-1:0]     POS_LIM = ACC_W'((64'd1 << (VEC_W - 1)) - 64'd1);
	localparam logic [ACC_W-1:0]     NEG_LIM = ACC_W'(64'd1 << (VEC_W - 1));
	localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
	localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

	logic signed [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]         mag_s1;
	logic                     neg_s1;
	logic                     big_s2;
	logic [VEC_W-1:0]         hp_s2;
	logic [ACC_W-1:0]         lp_s2;
	logic                     sat_s3;
	logic [ACC_W-1:0]         q_s3;
	logic signed [VEC_W-1:0]  vec_s4;

	assign vec = vec_s4;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= acc;
		end
		// sign and magnitude
		if (ctl.mag) begin
			neg_s1 <= acc_q[ACC_W-1];
			mag_s1 <= acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
		end
		// split magnitude into a 16-bit upper part and a 32-bit lower part against the gain
		if (ctl.mul) begin
			big_s2 <= (mag_s1[ACC_W-1:48] != '0);
			hp_s2  <= mag_s1[47:32] * gain;
			lp_s2  <= mag_s1[31:0] * gain;
		end
		// recombine, rounding the magnitude up for negative values
		if (ctl.comb) begin
			sat_s3 <= big_s2 || hp_s2[VEC_W-1];
			q_s3   <= ACC_W'({hp_s2[VEC_W-2:0], 16'h0000})
			        + ACC_W'(lp_s2[ACC_W-1:16])
			        + ACC_W'(neg_s1 && (lp_s2[15:0] != 16'h0000));
		end
		if (ctl.fin) begin
			if (sat_s3) begin
				vec_s4 <= neg_s1 ? VEC_MIN : VEC_MAX;
			end else if (neg_s1) begin
				vec_s4 <= (q_s3 > NEG_LIM) ? VEC_MIN : (~q_s3[VEC_W-1:0] + 1'b1);
			end else begin
				vec_s4 <= (q_s3 > POS_LIM) ? VEC_MAX : q_s3[VEC_W-1:0];
			end
		end
	end

endmodule

[src/sbdf_core.sv]
// back end: phasor recurrence, sample accumulation and sub-vector emission sequencer
module sbdf_core import sbdf_pkg::*; #(
	parameter int MAX_POINTS = SBDF_MAX_POINTS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [COEF_W-1:0] coef_a,
	input  logic signed [COEF_W-1:0] coef_b,
	input  logic [GAIN_W-1:0]        norm_gain,
	input  logic [PPV_W-1:0]         ppv,
	input  logic                     in_valid,
	input  in_item_t                 in_item,
	output logic                     in_rd,
	input  logic                     out_ready,
	output logic                     out_push,
	output result_t                  out_item
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SP_W  = SAMPLE_W + COEF_W;
	localparam int PP_W  = 2 * COEF_W;
	localparam int NX_W  = COEF_W + 4;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ACC  = 3'd1;
	localparam logic [2:0] ST_MAG  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_COMB = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_SUM  = 3'd6;
	localparam logic [2:0] ST_PUSH = 3'd7;

	localparam logic signed [COEF_W-1:0] Q30_ONE = COEF_W'(64'd1 << 30);

	function automatic logic signed [COEF_W-1:0] sat_phasor(input logic signed [NX_W-1:0] v);
		logic signed [COEF_W-1:0] r;
		if (v[NX_W-1:COEF_W-1] == '0 || v[NX_W-1:COEF_W-1] == '1) begin
			r = v[COEF_W-1:0];
		end else begin
			r = v[NX_W-1] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
		logic signed [SUM_W-1:0] r;
		if (v[SUM_W] == v[SUM_W-1]) begin
			r = v[SUM_W-1:0];
		end else begin
			r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
		return r;
	endfunction

	logic [2:0]               state_q;
	logic signed [COEF_W-1:0] cos_q;
	logic signed [COEF_W-1:0] sin_q;
	logic signed [ACC_W-1:0]  acc_re_q;
	logic signed [ACC_W-1:0]  acc_im_q;
	logic [CNT_W-1:0]         count_q;
	logic [VIDX_W-1:0]        vcount_q;
	logic signed [SUM_W-1:0]  sum_re_q;
	logic signed [SUM_W-1:0]  sum_im_q;

	logic signed [SP_W-1:0]   pc_s1;
	logic signed [SP_W-1:0]   ps_s1;
	logic signed [PP_W-1:0]   ac_s1;
	logic signed [PP_W-1:0]   bs_s1;
	logic signed [PP_W-1:0]   as_s1;
	logic signed [PP_W-1:0]   bc_s1;
	logic signed [COEF_W-1:0] cos_s1;
	logic signed [COEF_W-1:0] sin_s1;

	logic signed [COEF_W-1:0] cos_eff;
	logic signed [COEF_W-1:0] sin_eff;
	logic signed [ACC_W-1:0]  acc_re_new;
	logic signed [ACC_W-1:0]  acc_im_new;
	logic signed [NX_W-1:0]   nc;
	logic signed [NX_W-1:0]   ns;
	logic [CNT_W-1:0]         len_eff;
	logic [CNT_W-1:0]         count_next;
	logic                     emit;
	logic                     take;
	scale_ctl_t               sctl;
	logic signed [VEC_W-1:0]  vec_re;
	logic signed [VEC_W-1:0]  vec_im;

	// a restart request takes the phasor from its reset value
	assign cos_eff = in_item.start_req ? Q30_ONE : cos_q;
	assign sin_eff = in_item.start_req ? '0 : sin_q;

	assign in_rd = (state_q == ST_IDLE);
	assign take  = in_rd && in_valid;

	// zero length acts as one, oversize lengths clip to the maximum
	always_comb begin
		if (ppv == '0) begin
			len_eff = CNT_W'(1);
		end else if (32'(ppv) > 32'(MAX_POINTS)) begin
			len_eff = CNT_W'(MAX_POINTS);
		end else begin
			len_eff = CNT_W'(ppv);
		end
	end

	assign acc_re_new = acc_re_q + ACC_W'($signed(pc_s1[SP_W-1:16]));
	assign acc_im_new = acc_im_q + ACC_W'($signed(ps_s1[SP_W-1:16]));

	assign nc = NX_W'($signed(ac_s1[PP_W-1:30])) - NX_W'($signed(bs_s1[PP_W-1:30]))
	          + NX_W'(cos_s1);
	assign ns = NX_W'($signed(as_s1[PP_W-1:30])) + NX_W'($signed(bc_s1[PP_W-1:30]))
	          + NX_W'(sin_s1);

	assign count_next = count_q + 1'b1;
	assign emit       = (count_next >= len_eff);

	always_comb begin
		sctl.load = (state_q == ST_ACC) && emit;
		sctl.mag  = (state_q == ST_MAG);
		sctl.mul  = (state_q == ST_MUL);
		sctl.comb = (state_q == ST_COMB);
		sctl.fin  = (state_q == ST_FIN);
	end

	sbdf_scale u_scale_re (
		.clk  (clk),
		.ctl  (sctl),
		.acc  (acc_re_new),
		.gain (norm_gain),
		.vec  (vec_re)
	);

	sbdf_scale u_scale_im (
		.clk  (clk),
		.ctl  (sctl),
		.acc  (acc_im_new),
		.gain (norm_gain),
		.vec  (vec_im)
	);

	assign out_push = (state_q == ST_PUSH) && out_ready;

	always_comb begin
		out_item.vec_real     = vec_re;
		out_item.vec_imag     = vec_im;
		out_item.total_real   = sum_re_q;
		out_item.total_imag   = sum_im_q;
		out_item.vector_index = vcount_q;
	end

	// products of the current sample step
	always_ff @(posedge clk) begin
		if (take) begin
			pc_s1  <= in_item.sample * cos_eff;
			ps_s1  <= in_item.sample * sin_eff;
			ac_s1  <= coef_a * cos_eff;
			bs_s1  <= coef_b * sin_eff;
			as_s1  <= coef_a * sin_eff;
			bc_s1  <= coef_b * cos_eff;
			cos_s1 <= cos_eff;
			sin_s1 <= sin_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cos_q    <= Q30_ONE;
			sin_q    <= '0;
			acc_re_q <= '0;
			acc_im_q <= '0;
			count_q  <= '0;
			vcount_q <= '0;
			sum_re_q <= '0;
			sum_im_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (in_item.start_req) begin
							acc_re_q <= '0;
							acc_im_q <= '0;
							count_q  <= '0;
							vcount_q <= '0;
							sum_re_q <= '0;
							sum_im_q <= '0;
						end
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					cos_q <= sat_phasor(nc);
					sin_q <= sat_phasor(ns);
					if (emit) begin
						acc_re_q <= '0;
						acc_im_q <= '0;
						count_q  <= '0;
						state_q  <= ST_MAG;
					end else begin
						acc_re_q <= acc_re_new;
						acc_im_q <= acc_im_new;
						count_q  <= count_next;
						state_q  <= ST_IDLE;
					end
				end
				ST_MAG:  state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_COMB;
				ST_COMB: state_q <= ST_FIN;
				ST_FIN:  state_q <= ST_SUM;
				ST_SUM: begin
					sum_re_q <= sat_sum((SUM_W+1)'(sum_re_q) + (SUM_W+1)'(vec_re));
					sum_im_q <= sat_sum((SUM_W+1)'(sum_im_q) + (SUM_W+1)'(vec_im));
					state_q  <= ST_PUSH;
				end
				ST_PUSH: begin
					if (out_ready) begin
						vcount_q <= vcount_q + 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[src/sbdf_outq.sv]
// result holding register seen by the receiver as a one-entry queue
module sbdf_outq import sbdf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t wr_item,
	output logic    ready,
	output logic    empty,
	input  logic    pop,
	output result_t rd_item
);

	logic    valid_q;
	result_t data_q;

	assign empty   = !valid_q;
	assign ready   = !valid_q || pop;
	assign rd_item = data_q;

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

endmodule

[src/single_bin_dft_subvector_fold.sv]
// top level of the single-bin dft sub-vector folder
//
// usage
// - input side is a queue: drive sample and start_req, raise push while full is low;
//   start_req restarts the phasor, counters and sums before that sample is used
// - result side is a queue: while empty is low the oldest result is on vec_*, total_*
//   and vector_index; raise pop to take it
// - config side: cfg_valid/cfg_ready with cfg_index and cfg_data, cfg_ready is always
//   high; index 0 coef_a, 1 coef_b, 2 norm_gain, 3 points_per_vector, others ignored;
//   write only while the block is idle
// - sample pace: set by the phasor recurrence loop (four 32x32 products registered,
//   then the three-term add and saturate); a new sample is taken only from idle; the
//   last sample of a sub-vector adds the scaler pipeline, running sum and result write
// - result path: the last sample of a sub-vector passes the request queue, the idle and
//   accumulate states, the scaler stages, the running sum and the output register
// - a two-entry request queue in front lets the source run ahead by two samples
// - if the receiver stalls, the result stays in the output register, the core waits
//   for it with the next result, and the request queue then fills and raises full
// - reset clears the queues, the phasor to (1.0, 0.0), counters, sums and the
//   config registers to their defaults; no clearing pass is needed
module single_bin_dft_subvector_fold import sbdf_pkg::*; #(
	parameter int MAX_POINTS = SBDF_MAX_POINTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// sample requests
	input  logic                        push,
	output logic                        full,
	input  logic signed [SAMPLE_W-1:0]  sample,
	input  logic                        start_req,
	// results
	output logic                        empty,
	input  logic                        pop,
	output logic signed [VEC_W-1:0]     vec_real,
	output logic signed [VEC_W-1:0]     vec_imag,
	output logic signed [SUM_W-1:0]     total_real,
	output logic signed [SUM_W-1:0]     total_imag,
	output logic [VIDX_W-1:0]           vector_index,
	// register writes
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	logic signed [COEF_W-1:0] coef_a_q;
	logic signed [COEF_W-1:0] coef_b_q;
	logic [GAIN_W-1:0]        norm_gain_q;
	logic [PPV_W-1:0]         ppv_q;

	in_item_t in_wr;
	in_item_t in_head;
	logic     in_valid;
	logic     in_rd;
	result_t  res_wr;
	result_t  res_head;
	logic     res_push;
	logic     res_ready;

	assign cfg_ready = 1'b1;

	// register file, unknown indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q    <= COEF_A_RST;
			coef_b_q    <= COEF_B_RST;
			norm_gain_q <= NORM_GAIN_RST;
			ppv_q       <= PPV_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COEF_A:    coef_a_q    <= cfg_data;
				REG_COEF_B:    coef_b_q    <= cfg_data;
				REG_NORM_GAIN: norm_gain_q <= cfg_data;
				REG_PPV:       ppv_q       <= cfg_data[PPV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		in_wr.sample    = sample;
		in_wr.start_req = start_req;
	end

	// front: sample request queue
	sbdf_inq u_inq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (in_wr),
		.full     (full),
		.rd       (in_rd),
		.rd_valid (in_valid),
		.rd_item  (in_head)
	);

	// back: recurrence, accumulation and emission
	sbdf_core #(
		.MAX_POINTS (MAX_POINTS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef_a    (coef_a_q),
		.coef_b    (coef_b_q),
		.norm_gain (norm_gain_q),
		.ppv       (ppv_q),
		.in_valid  (in_valid),
		.in_item   (in_head),
		.in_rd     (in_rd),
		.out_ready (res_ready),
		.out_push  (res_push),
		.out_item  (res_wr)
	);

	// result register toward the receiver
	sbdf_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_item (res_wr),
		.ready   (res_ready),
		.empty   (empty),
		.pop     (pop),
		.rd_item (res_head)
	);

	assign vec_real     = res_head.vec_real;
	assign vec_imag     = res_head.vec_imag;
	assign total_real   = res_head.total_real;
	assign total_imag   = res_head.total_imag;
	assign vector_index = res_head.vector_index;

endmodule

[test/single_bin_dft_subvector_fold_tb.sv]
// self-checking testbench for the single-bin dft sub-vector folder
module single_bin_dft_subvector_fold_tb import sbdf_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// register indexes past the mapped four are decoded as nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 4'd15;

	// 22.5 degree step: a = -2 sin^2(theta/2), b = sin(theta), both Q1.30
	localparam logic [CFG_DATA_W-1:0] ROT_A = -32'sd81733760;
	localparam logic [CFG_DATA_W-1:0] ROT_B = 32'sd410903172;

	localparam int RAND_PHASES    = 12;
	localparam int RAND_PER_PHASE = 155;
	localparam int OVERSIZE_ITEMS = 24;
	localparam int SETTLE_CYCLES  = 24;
	localparam int MAX_REPORTS    = 100;
	localparam longint TIMEOUT_NS = 64'd5_000_000;

	// ports of the block; every input starts at a known value
	logic                       clk;
	logic                       arst_n    = 1'b0;
	logic                       push      = 1'b0;
	logic                       full;
	logic signed [SAMPLE_W-1:0] sample    = '0;
	logic                       start_req = 1'b0;
	logic                       empty;
	logic                       pop       = 1'b0;
	logic signed [VEC_W-1:0]    vec_real;
	logic signed [VEC_W-1:0]    vec_imag;
	logic signed [SUM_W-1:0]    total_real;
	logic signed [SUM_W-1:0]    total_imag;
	logic [VIDX_W-1:0]          vector_index;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data  = '0;

	// sample requests waiting for the driver, sub-vectors waiting for the block
	in_item_t sample_q[$];
	result_t  subvec_q[$];
	in_item_t drv_req;
	result_t  new_vec;
	result_t  want_vec;

	// idle percentages of sender and receiver, changed per phase
	int send_idle_pct;
	int recv_idle_pct;

	int n_samples;
	int n_results;
	int n_writes;
	int n_fail;

	// predictor copy of the registers
	longint               m_coef_a;
	longint               m_coef_b;
	logic [GAIN_W-1:0]    m_gain;
	logic [PPV_W-1:0]     m_ppv;
	// predictor copy of the running state
	longint               m_cos;
	longint               m_sin;
	longint               m_acc_re;
	longint               m_acc_im;
	longint               m_sum_re;
	longint               m_sum_im;
	int unsigned          m_nsamp;
	logic [VIDX_W-1:0]    m_vidx;

	single_bin_dft_subvector_fold i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint clamp(longint x, int w);
		longint hi;
		hi = (64'sd1 <<< (w - 1)) - 1;
		if (x > hi)
			return hi;
		if (x < -hi - 1)
			return -hi - 1;
		return x;
	endfunction

	// 64-bit accumulate that sticks at the rails instead of wrapping
	function automatic longint add_sat64(longint a, longint b);
		logic signed [64:0] t;
		t = a;
		t = t + b;
		if (t[64] != t[63])
			return t[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		return t[63:0];
	endfunction

	// floor(acc * gain / 2^16) with the gain unsigned, saturated to the vector width
	function automatic longint apply_gain(longint acc, logic [GAIN_W-1:0] g);
		logic signed [96:0] p;
		logic signed [96:0] gx;
		logic signed [96:0] lim;
		p = acc;
		gx = g;
		lim = (97'sd1 <<< (VEC_W - 1)) - 1;
		p = (p * gx) >>> 16;
		if (p > lim)
			p = lim;
		else if (p < -lim - 1)
			p = -lim - 1;
		return p[63:0];
	endfunction

	// phasor back to (1.0, 0.0), counters and all sums cleared
	function automatic void clear_run();
		m_cos = 64'sd1 <<< 30;
		m_sin = 0;
		m_acc_re = 0;
		m_acc_im = 0;
		m_sum_re = 0;
		m_sum_im = 0;
		m_nsamp = 0;
		m_vidx = '0;
	endfunction

	// one accepted sample request; returns 1 when it closes a sub-vector
	function automatic bit fold_sample(input logic signed [SAMPLE_W-1:0] smp,
			input logic restart, output result_t res);
		longint s;
		longint nc;
		longint ns;
		longint vr;
		longint vi;
		int unsigned len;
		s = smp;
		len = m_ppv;
		res = '0;
		if (restart)
			clear_run();
		// zero length behaves as one, anything past the maximum as the maximum
		if (len == 0)
			len = 1;
		if (len > SBDF_MAX_POINTS)
			len = SBDF_MAX_POINTS;

		// sample times Q1.30 phasor, brought down to Q.14
		m_acc_re = add_sat64(m_acc_re, (s * m_cos) >>> 16);
		m_acc_im = add_sat64(m_acc_im, (s * m_sin) >>> 16);

		// rotate the phasor with the configured recurrence
		nc = ((m_coef_a * m_cos) >>> 30) - ((m_coef_b * m_sin) >>> 30) + m_cos;
		ns = ((m_coef_a * m_sin) >>> 30) + ((m_coef_b * m_cos) >>> 30) + m_sin;
		m_cos = clamp(nc, COEF_W);
		m_sin = clamp(ns, COEF_W);

		// a length lowered below the count closes the vector on this sample
		m_nsamp++;
		if (m_nsamp < len)
			return 1'b0;

		vr = apply_gain(m_acc_re, m_gain);
		vi = apply_gain(m_acc_im, m_gain);
		m_sum_re = clamp(m_sum_re + vr, SUM_W);
		m_sum_im = clamp(m_sum_im + vi, SUM_W);
		res.vec_real = vr[VEC_W-1:0];
		res.vec_imag = vi[VEC_W-1:0];
		res.total_real = m_sum_re[SUM_W-1:0];
		res.total_imag = m_sum_im[SUM_W-1:0];
		res.vector_index = m_vidx;
		// index wraps at 16 bits by the width of m_vidx
		m_vidx = m_vidx + 1'b1;
		m_nsamp = 0;
		m_acc_re = 0;
		m_acc_im = 0;
		return 1'b1;
	endfunction

	function automatic void check_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
		if (got !== want) begin
			n_fail++;
			if (n_fail <= MAX_REPORTS)
				$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	// ---------------------------------------------------------------- drivers

	// sample requests: a request held against full stays put until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || !full) begin
			if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_req = sample_q.pop_front();
				push <= 1'b1;
				sample <= drv_req.sample;
				start_req <= drv_req.start_req;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result side stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------- monitor

	// register writes and sample requests feed the predictor, results are compared
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_coef_a = COEF_A_RST;
			m_coef_b = COEF_B_RST;
			m_gain = NORM_GAIN_RST;
			m_ppv = PPV_RST;
			clear_run();
			subvec_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				n_writes++;
				case (cfg_index)
					REG_COEF_A: m_coef_a = $signed(cfg_data);
					REG_COEF_B: m_coef_b = $signed(cfg_data);
					REG_NORM_GAIN: m_gain = cfg_data;
					REG_PPV: m_ppv = cfg_data[PPV_W-1:0];
					default: ;
				endcase
			end
			if (!empty && pop) begin
				n_results++;
				if (subvec_q.size() == 0) begin
					n_fail++;
					if (n_fail <= MAX_REPORTS)
						$error("sub-vector result with nothing pending, index %0d",
							vector_index);
				end else begin
					want_vec = subvec_q.pop_front();
					check_field("vec_real", want_vec.vec_real, vec_real);
					check_field("vec_imag", want_vec.vec_imag, vec_imag);
					check_field("total_real", want_vec.total_real, total_real);
					check_field("total_imag", want_vec.total_imag, total_imag);
					check_field("vector_index", want_vec.vector_index, vector_index);
				end
			end
			if (push && !full) begin
				n_samples++;
				if (fold_sample(sample, start_req, new_vec))
					subvec_q.push_back(new_vec);
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic queue_sample(logic signed [SAMPLE_W-1:0] s, logic restart);
		in_item_t it;
		it.sample = s;
		it.start_req = restart;
		sample_q.push_back(it);
	endtask

	// hold the sender until every expected sub-vector is out, then let the
	// pipeline settle since a trailing sample may still be in flight
	task automatic drain();
		@(negedge clk);
		while (sample_q.size() != 0 || push || subvec_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(15))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return '0;
			3: return '1;
			default: return SAMPLE_W'($urandom_range(16'hFFFF));
		endcase
	endfunction

	initial begin : stim
		logic [CFG_DATA_W-1:0] ca;
		logic [CFG_DATA_W-1:0] cb;
		logic [CFG_DATA_W-1:0] gain_w;
		logic [CFG_DATA_W-1:0] len_w;
		longint rot;

		send_idle_pct = 13;
		recv_idle_pct = 87;
		n_samples = 0;
		n_results = 0;
		n_writes = 0;
		n_fail = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// zero length: every sample closes its own sub-vector
		write_reg(REG_COEF_A, ROT_A);
		write_reg(REG_COEF_B, ROT_B);
		write_reg(REG_NORM_GAIN, NORM_GAIN_RST);
		write_reg(REG_PPV, '0);
		queue_sample(16'sh7FFF, 1'b1);
		queue_sample(16'sh8000, 1'b0);
		queue_sample('0, 1'b0);
		queue_sample('1, 1'b0);
		queue_sample(16'sd1, 1'b0);
		drain();

		// full-scale gain over three-sample vectors, restart mid-run
		write_reg(REG_PPV, 32'd3);
		write_reg(REG_NORM_GAIN, '1);
		repeat (3) queue_sample(16'sh8000, 1'b0);
		queue_sample(16'sh7FFF, 1'b1);
		queue_sample(16'sh7FFF, 1'b0);
		queue_sample(16'sh8000, 1'b0);
		drain();

		// writes to unmapped indexes must change nothing
		write_reg(REG_UNMAPPED_LO, '1);
		write_reg(REG_UNMAPPED_HI, '0);

		// length lowered below the running count: next sample closes the vector
		write_reg(REG_PPV, 32'd7);
		write_reg(REG_NORM_GAIN, '0);
		queue_sample(16'sd123, 1'b0);
		queue_sample(-16'sd5, 1'b0);
		queue_sample(16'sh7FFF, 1'b0);
		queue_sample(16'sh8000, 1'b0);
		drain();
		write_reg(REG_PPV, 32'd2);
		queue_sample(16'sd77, 1'b0);
		drain();

		// coefficient extremes drive the phasor into saturation
		write_reg(REG_COEF_A, 32'h7FFF_FFFF);
		write_reg(REG_COEF_B, 32'h8000_0000);
		write_reg(REG_NORM_GAIN, 32'd1);
		write_reg(REG_PPV, 32'd1);
		queue_sample(16'sd1234, 1'b1);
		queue_sample(16'sh8000, 1'b0);
		queue_sample(16'sh7FFF, 1'b0);
		queue_sample('0, 1'b0);
		drain();

		// random phases: sender idles lightly first, then the receiver, then neither
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph * 3 / RAND_PHASES)
				0: begin
					send_idle_pct = 13;
					recv_idle_pct = 87;
				end
				1: begin
					send_idle_pct = 87;
					recv_idle_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase

			case ($urandom_range(3))
				0: begin
					// small step with a near -b^2/2 so the phasor stays near unit length
					rot = $urandom_range(32'h4000_0000);
					rot = rot - 64'sh2000_0000;
					cb = rot[31:0];
					rot = -((rot * rot) >>> 31);
					ca = rot[31:0];
				end
				1: begin
					ca = $urandom;
					cb = $urandom;
				end
				2: begin
					ca = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
					cb = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				end
				default: begin
					ca = '0;
					cb = '0;
				end
			endcase
			case ($urandom_range(3))
				0: gain_w = NORM_GAIN_RST;
				1: gain_w = '1;
				2: gain_w = $urandom_range(32'h3_FFFF);
				default: gain_w = $urandom;
			endcase
			case ($urandom_range(7))
				0: len_w = '0;
				1: len_w = $urandom_range(40, 9);
				default: len_w = $urandom_range(8, 1);
			endcase
			// bits above the length register are dropped by the block
			len_w[CFG_DATA_W-1:PPV_W] = (CFG_DATA_W-PPV_W)'($urandom);

			write_reg(REG_COEF_A, ca);
			write_reg(REG_COEF_B, cb);
			write_reg(REG_NORM_GAIN, gain_w);
			write_reg(REG_PPV, len_w);
			if ($urandom_range(3) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_HI, REG_UNMAPPED_LO)),
					$urandom);

			for (int k = 0; k < RAND_PER_PHASE; k++)
				queue_sample(rand_sample(),
					(k == 0 && $urandom_range(1) == 1) || $urandom_range(31) == 0);
			drain();
		end

		// oversize length clamps to the maximum, so nothing closes; lowering it
		// then closes the partial vector, and full-scale input with the largest
		// gain saturates the scaled vector
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_COEF_A, '0);
		write_reg(REG_COEF_B, '0);
		write_reg(REG_NORM_GAIN, '1);
		write_reg(REG_PPV, 32'h0001_FFFF);
		for (int k = 0; k < OVERSIZE_ITEMS; k++)
			queue_sample(($urandom_range(9) == 0) ? rand_sample() : 16'sh8000, k == 0);
		drain();
		write_reg(REG_PPV, 32'd1);
		queue_sample(16'sh8000, 1'b0);
		drain();

		$display("checked %0d sub-vectors from %0d sample requests over %0d register writes",
			n_results, n_samples, n_writes);
		$display("lengths zero, lowered, oversize and random; gain and phasor rails; "
			, "%0d mismatches", n_fail);
		if (n_fail == 0 && subvec_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// hang guard, several times the slowest legal run
	initial begin
		#(TIMEOUT_NS);
		$display("FAILURE");
		$finish;
	end

endmodule
